[design/assert_macros.svh]
// Assertion macros used by the level-set normal top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/lsn_pkg.sv]
// Package: types, constants and register codes of the level-set normal unit.
`default_nettype none
package lsn_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int PHI_W      = 32;
  localparam int SPAN_W     = 31;
  localparam int FLAG_W     = 8;
  localparam int NORM_W     = 32;
  localparam int GMAG_W     = 32;
  localparam int FRAC_IN    = 16;
  localparam int FRAC_OUT   = 30;
  localparam int THR_W      = 7;
  localparam int EPS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(4);
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER_THRESHOLD = 2'd0,
    CFG_NORM_EPSILON    = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [PHI_W-1:0]  phi_east;
    logic signed [PHI_W-1:0]  phi_west;
    logic signed [PHI_W-1:0]  phi_north;
    logic signed [PHI_W-1:0]  phi_south;
    logic signed [PHI_W-1:0]  phi_top;
    logic signed [PHI_W-1:0]  phi_bottom;
    logic [SPAN_W-1:0]        span_x;
    logic [SPAN_W-1:0]        span_y;
    logic [SPAN_W-1:0]        span_z;
    logic signed [FLAG_W-1:0] layer_flag;
  } in_item_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     masked;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
  } cfg_req_t;

endpackage
`default_nettype wire

[design/lsn_if.sv]
// Interfaces: cell request, normal result and configuration write channels.
`default_nettype none
interface lsn_in_if;
  logic               valid;
  logic               ready;
  lsn_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsn_out_if;
  logic               valid;
  logic               ready;
  lsn_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lsn_cfg_if;
  logic              valid;
  logic              ready;
  lsn_pkg::cfg_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/lsn_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module lsn_div #(
  parameter int NUM_W  = 49,
  parameter int DEN_W  = 31,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic      [NUM_W-1:0]  quo_o,
  output logic      [SIDE_W-1:0] side_o
);

  logic [DEN_W-1:0]  rem  [NUM_W+1];
  logic [NUM_W-1:0]  num  [NUM_W+1];
  logic [NUM_W-1:0]  quo  [NUM_W+1];
  logic [DEN_W-1:0]  den  [NUM_W+1];
  logic [SIDE_W-1:0] side [NUM_W+1];

  assign rem[0]  = '0;
  assign num[0]  = num_i;
  assign quo[0]  = '0;
  assign den[0]  = den_i;
  assign side[0] = side_i;

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    logic [DEN_W:0] diff;
    always_comb begin
      trial = {rem[s], num[s][NUM_W-1]};
      ge    = trial >= {1'b0, den[s]};
      diff  = trial - {1'b0, den[s]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[s+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        num[s+1]  <= num[s] << 1;
        quo[s+1]  <= {quo[s][NUM_W-2:0], ge};
        den[s+1]  <= den[s];
        side[s+1] <= side[s];
      end
    end
  end

  assign quo_o  = quo[NUM_W];
  assign side_o = side[NUM_W];

endmodule
`default_nettype wire

[design/lsn_sqrt.sv]
// Pipelined integer square root, one root bit per stage, with sideband.
`default_nettype none
module lsn_sqrt #(
  parameter int RAD_W  = 64,
  parameter int SIDE_W = 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [RAD_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]    side_i,
  output logic      [RAD_W/2-1:0]   root_o,
  output logic      [SIDE_W-1:0]    side_o
);

  localparam int ROOT_W = RAD_W / 2;

  logic [ROOT_W:0]   rem  [ROOT_W+1];
  logic [RAD_W-1:0]  rad  [ROOT_W+1];
  logic [ROOT_W-1:0] root [ROOT_W+1];
  logic [SIDE_W-1:0] side [ROOT_W+1];

  assign rem[0]  = '0;
  assign rad[0]  = rad_i;
  assign root[0] = '0;
  assign side[0] = side_i;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [ROOT_W+2:0] cur;
    logic [ROOT_W+2:0] trial;
    logic              ge;
    logic [ROOT_W+2:0] diff;
    always_comb begin
      cur   = {rem[s], rad[s][RAD_W-1 -: 2]};
      trial = {1'b0, root[s], 2'b01};
      ge    = cur >= trial;
      diff  = cur - trial;
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[s+1]  <= ge ? diff[ROOT_W:0] : cur[ROOT_W:0];
        rad[s+1]  <= rad[s] << 2;
        root[s+1] <= {root[s][ROOT_W-2:0], ge};
        side[s+1] <= side[s];
      end
    end
  end

  assign root_o = root[ROOT_W];
  assign side_o = side[ROOT_W];

endmodule
`default_nettype wire

[design/level_set_unit_normal.sv]
// Top level: level-set unit normal by central differences, fully pipelined.
//
// Usage:
//  - in_i carries one cell request: six neighbor phi values (Q16.16), three
//    summed spacings and the layer flag. Accepted when valid and ready.
//  - out_o returns one result per request, in order: Q2.30 normal and the
//    masked bit. Masked cells give a zero normal.
//  - cfg_i writes layer_threshold (index 0) or norm_epsilon (index 1); other
//    indexes are ignored. Always ready; write only while the pipe is empty.
//  - A request passes through 149 register stages: one input stage, a 49-stage
//    gradient divider, clamp, square and sum stages, a 32-stage square root, a
//    divisor stage, a 62-stage normalize divider and the output register.
//    Throughput is one cell per cycle while the receiver does not stall.
//  - The whole pipe advances on one enable. When the receiver stalls with a
//    result waiting, every stage holds and in_i.ready drops; nothing is lost
//    or repeated. Empty slots travel with the data and are not compacted.
//  - Reset clears all valid bits and loads threshold 4 and epsilon 1.
`default_nettype none
`include "assert_macros.svh"
module level_set_unit_normal #(
  parameter int VALUE_WIDTH = lsn_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lsn_in_if.sink     in_i,
  lsn_cfg_if.sink    cfg_i,
  lsn_out_if.source  out_o
);

  localparam int GRAD_BITS = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int GW   = lsn_pkg::GMAG_W;
  localparam int D1_N = lsn_pkg::PHI_W + 1 + lsn_pkg::FRAC_IN;     // 49
  localparam int D1_D = lsn_pkg::SPAN_W;
  localparam int SQ_W = 2 * GW;
  localparam int RT_W = SQ_W / 2;
  localparam int D2_N = GW + lsn_pkg::FRAC_OUT;                     // 62
  localparam int D2_D = RT_W + 1;
  localparam int LAT  = 1 + D1_N + 3 + RT_W + 1 + D2_N + 1;
  localparam logic [GW-1:0] LIM_NEG = GW'(64'd1 << (GRAD_BITS - 1));
  localparam logic [GW-1:0] LIM_POS = LIM_NEG - GW'(1);
  localparam logic [D2_N-1:0] ONE_OUT = D2_N'(64'd1 << lsn_pkg::FRAC_OUT);

  // config registers
  logic [lsn_pkg::THR_W-1:0] thr_q;
  logic [lsn_pkg::EPS_W-1:0] eps_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= lsn_pkg::THR_RESET;
      eps_q <= lsn_pkg::EPS_RESET;
    end else if (cfg_i.valid) begin
      unique case (lsn_pkg::cfg_reg_e'(cfg_i.data.idx))
        lsn_pkg::CFG_LAYER_THRESHOLD: thr_q <= cfg_i.data.value[lsn_pkg::THR_W-1:0];
        lsn_pkg::CFG_NORM_EPSILON:    eps_q <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // global advance; valid bits run alongside the data
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // ---- stage 1: differences, masking decision
  function automatic logic [lsn_pkg::PHI_W:0] diff_mag(
    input logic signed [lsn_pkg::PHI_W-1:0] p,
    input logic signed [lsn_pkg::PHI_W-1:0] m,
    output logic neg
  );
    logic signed [lsn_pkg::PHI_W:0] d;
    d   = {p[lsn_pkg::PHI_W-1], p} - {m[lsn_pkg::PHI_W-1], m};
    neg = d[lsn_pkg::PHI_W];
    return neg ? -d : d;
  endfunction

  logic [lsn_pkg::PHI_W:0]  mx, my, mz;
  logic                     nx, ny, nz;
  logic [lsn_pkg::FLAG_W-1:0] fmag;
  logic                     mask_d;

  always_comb begin
    mx = diff_mag(in_i.data.phi_east,  in_i.data.phi_west,   nx);
    my = diff_mag(in_i.data.phi_north, in_i.data.phi_south,  ny);
    mz = diff_mag(in_i.data.phi_top,   in_i.data.phi_bottom, nz);
    fmag = in_i.data.layer_flag[lsn_pkg::FLAG_W-1] ?
           -in_i.data.layer_flag : in_i.data.layer_flag;
    mask_d = fmag > {{(lsn_pkg::FLAG_W - lsn_pkg::THR_W){1'b0}}, thr_q};
  end

  logic [D1_N-1:0] s1_nx_q, s1_ny_q, s1_nz_q;
  logic [D1_D-1:0] s1_sx_q, s1_sy_q, s1_sz_q;
  logic [2:0]      s1_neg_q, s1_zero_q;
  logic            s1_mask_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_nx_q   <= {mx, {lsn_pkg::FRAC_IN{1'b0}}};
      s1_ny_q   <= {my, {lsn_pkg::FRAC_IN{1'b0}}};
      s1_nz_q   <= {mz, {lsn_pkg::FRAC_IN{1'b0}}};
      s1_sx_q   <= in_i.data.span_x;
      s1_sy_q   <= in_i.data.span_y;
      s1_sz_q   <= in_i.data.span_z;
      s1_neg_q  <= {nx, ny, nz};
      s1_zero_q <= {mx == '0, my == '0, mz == '0};
      s1_mask_q <= mask_d;
    end
  end

  // ---- gradient dividers
  logic [D1_N-1:0] q1x, q1y, q1z;
  logic [2:0]      d1x_side;
  logic [1:0]      d1y_side, d1z_side;

  lsn_div #(.NUM_W(D1_N), .DEN_W(D1_D), .SIDE_W(3)) u_grad_x (
    .clk_i, .en_i(en), .num_i(s1_nx_q), .den_i(s1_sx_q),
    .side_i({s1_mask_q, s1_neg_q[2], s1_zero_q[2]}), .quo_o(q1x), .side_o(d1x_side)
  );
  lsn_div #(.NUM_W(D1_N), .DEN_W(D1_D), .SIDE_W(2)) u_grad_y (
    .clk_i, .en_i(en), .num_i(s1_ny_q), .den_i(s1_sy_q),
    .side_i({s1_neg_q[1], s1_zero_q[1]}), .quo_o(q1y), .side_o(d1y_side)
  );
  lsn_div #(.NUM_W(D1_N), .DEN_W(D1_D), .SIDE_W(2)) u_grad_z (
    .clk_i, .en_i(en), .num_i(s1_nz_q), .den_i(s1_sz_q),
    .side_i({s1_neg_q[0], s1_zero_q[0]}), .quo_o(q1z), .side_o(d1z_side)
  );

  // ---- stage 2: saturate gradient magnitudes
  function automatic logic [GW-1:0] grad_clamp(
    input logic [D1_N-1:0] q, input logic neg, input logic zero
  );
    logic [GW-1:0] lim;
    lim = neg ? LIM_NEG : LIM_POS;
    if (zero) return '0;
    if (q > {{(D1_N - GW){1'b0}}, lim}) return lim;
    return q[GW-1:0];
  endfunction

  logic [GW-1:0] s2_gx_q, s2_gy_q, s2_gz_q;
  logic [2:0]    s2_neg_q;
  logic          s2_mask_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_gx_q   <= grad_clamp(q1x, d1x_side[1], d1x_side[0]);
      s2_gy_q   <= grad_clamp(q1y, d1y_side[1], d1y_side[0]);
      s2_gz_q   <= grad_clamp(q1z, d1z_side[1], d1z_side[0]);
      s2_neg_q  <= {d1x_side[1], d1y_side[1], d1z_side[1]};
      s2_mask_q <= d1x_side[2];
    end
  end

  // ---- stage 3: squares
  logic [SQ_W-1:0] s3_sqx_q, s3_sqy_q, s3_sqz_q;
  logic [GW-1:0]   s3_gx_q, s3_gy_q, s3_gz_q;
  logic [2:0]      s3_neg_q;
  logic            s3_mask_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_sqx_q  <= SQ_W'(s2_gx_q) * SQ_W'(s2_gx_q);
      s3_sqy_q  <= SQ_W'(s2_gy_q) * SQ_W'(s2_gy_q);
      s3_sqz_q  <= SQ_W'(s2_gz_q) * SQ_W'(s2_gz_q);
      s3_gx_q   <= s2_gx_q;
      s3_gy_q   <= s2_gy_q;
      s3_gz_q   <= s2_gz_q;
      s3_neg_q  <= s2_neg_q;
      s3_mask_q <= s2_mask_q;
    end
  end

  // ---- stage 4: sum of squares (fits 64 bits, each term is at most 2^62)
  localparam int SQ_SIDE = 1 + 3 + 3 * GW;
  logic [SQ_W-1:0]    s4_sum_q;
  logic [SQ_SIDE-1:0] s4_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_sum_q  <= s3_sqx_q + s3_sqy_q + s3_sqz_q;
      s4_side_q <= {s3_mask_q, s3_neg_q, s3_gx_q, s3_gy_q, s3_gz_q};
    end
  end

  // ---- magnitude
  logic [RT_W-1:0]    root;
  logic [SQ_SIDE-1:0] rt_side;

  lsn_sqrt #(.RAD_W(SQ_W), .SIDE_W(SQ_SIDE)) u_mag (
    .clk_i, .en_i(en), .rad_i(s4_sum_q), .side_i(s4_side_q),
    .root_o(root), .side_o(rt_side)
  );

  // ---- stage 5: divisor and normalize numerators
  logic [D2_D-1:0] div_d;
  assign div_d = D2_D'(root) + D2_D'(eps_q);

  logic [D2_D-1:0] s5_div_q;
  logic [D2_N-1:0] s5_nx_q, s5_ny_q, s5_nz_q;
  logic [2:0]      s5_neg_q;
  logic            s5_mask_q, s5_dz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_div_q  <= div_d;
      s5_dz_q   <= div_d == '0;
      s5_nx_q   <= {rt_side[3*GW-1 -: GW], {lsn_pkg::FRAC_OUT{1'b0}}};
      s5_ny_q   <= {rt_side[2*GW-1 -: GW], {lsn_pkg::FRAC_OUT{1'b0}}};
      s5_nz_q   <= {rt_side[GW-1 -: GW],   {lsn_pkg::FRAC_OUT{1'b0}}};
      s5_neg_q  <= rt_side[3*GW+2 -: 3];
      s5_mask_q <= rt_side[SQ_SIDE-1];
    end
  end

  // ---- normalize dividers
  logic [D2_N-1:0] q2x, q2y, q2z;
  logic [2:0]      d2x_side;
  logic [1:0]      d2y_side, d2z_side;

  lsn_div #(.NUM_W(D2_N), .DEN_W(D2_D), .SIDE_W(3)) u_norm_x (
    .clk_i, .en_i(en), .num_i(s5_nx_q), .den_i(s5_div_q),
    .side_i({s5_mask_q, s5_neg_q[2], s5_dz_q}), .quo_o(q2x), .side_o(d2x_side)
  );
  lsn_div #(.NUM_W(D2_N), .DEN_W(D2_D), .SIDE_W(2)) u_norm_y (
    .clk_i, .en_i(en), .num_i(s5_ny_q), .den_i(s5_div_q),
    .side_i({s5_neg_q[1], s5_dz_q}), .quo_o(q2y), .side_o(d2y_side)
  );
  lsn_div #(.NUM_W(D2_N), .DEN_W(D2_D), .SIDE_W(2)) u_norm_z (
    .clk_i, .en_i(en), .num_i(s5_nz_q), .den_i(s5_div_q),
    .side_i({s5_neg_q[0], s5_dz_q}), .quo_o(q2z), .side_o(d2z_side)
  );

  // ---- output register: clamp to one, apply sign, force masked cells and zero divisors to zero
  function automatic logic [lsn_pkg::NORM_W-1:0] norm_out(
    input logic [D2_N-1:0] q, input logic neg, input logic dz, input logic mask
  );
    logic [D2_N-1:0]           c;
    logic [lsn_pkg::NORM_W-1:0] v;
    c = (q > ONE_OUT) ? ONE_OUT : q;
    v = c[lsn_pkg::NORM_W-1:0];
    if (dz || mask) return '0;
    return neg ? -v : v;
  endfunction

  lsn_pkg::out_item_t out_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.normal_x <= norm_out(q2x, d2x_side[1], d2x_side[0], d2x_side[2]);
      out_q.normal_y <= norm_out(q2y, d2y_side[1], d2y_side[0], d2x_side[2]);
      out_q.normal_z <= norm_out(q2z, d2z_side[1], d2z_side[0], d2x_side[2]);
      out_q.masked   <= d2x_side[2];
    end
  end

  assign out_o.data = out_q;

  // ---- checks
  `ASSERT_CLK(a_mask_zero, clk_i, rst_ni,
    out_o.valid && out_o.data.masked |->
      (out_o.data.normal_x == '0 && out_o.data.normal_y == '0 &&
       out_o.data.normal_z == '0), "masked result carries a nonzero normal")
  `ASSERT_CLK(a_unit_range, clk_i, rst_ni,
    out_o.valid |-> (out_o.data.normal_x <= 32'sh4000_0000 &&
                     out_o.data.normal_x >= -32'sh4000_0000),
    "normal_x outside plus or minus one")
  `ASSERT_CLK(a_no_accept_on_stall, clk_i, rst_ni,
    in_i.valid && in_i.ready |-> (!out_o.valid || out_o.ready),
    "request accepted while result stalled")
  `ASSERT_CLK(a_hold_on_stall, clk_i, rst_ni,
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data),
    "stalled result changed")

endmodule
`default_nettype wire
